### sv/dpa_pkg.sv
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared constants, types and lane arithmetic helpers for the dot-product
// accumulator.
// ----------------------------------------------------------------------------
package dpa_pkg;

   // Datapath sizing
   localparam int LANE_COUNT   = 8;
   localparam int INPUT_BITS   = 8;
   localparam int ACC_BITS     = 32;
   // Entry count is a power of two; the address is reduced by its low bits
   localparam int ENTRY_COUNT  = 512;

   // Fixed port widths
   localparam int VECTOR_BITS  = 64;
   localparam int PSUM_BITS    = 32;
   localparam int RESULT_BITS  = 32;
   localparam int ADDR_IN_BITS = 9;

   // Derived widths
   localparam int ADDR_BITS    = $clog2(ENTRY_COUNT);
   localparam int PROD_BITS    = 2 * INPUT_BITS;

   // Queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

   typedef logic [ACC_BITS-1:0]           acc_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [INPUT_BITS-1:0]  lane_type;
   typedef logic [ADDR_BITS-1:0]          index_type;

   // One classified transaction waiting for the accumulator update
   typedef struct packed {
      acc_type   total;
      index_type index;
      logic      accumulate;
      logic      final_item;
   } job_type;

   // Back-end status seen by the front end
   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_UPDATE
   } back_state_type;

   // Lane of a packed word; bits beyond the word read as zero
   function automatic lane_type lane_value(input logic [VECTOR_BITS-1:0] word,
                                           input int lane);
      lane_type v;
      int       pos;
      v = '0;
      for (int j = 0; j < INPUT_BITS; j++) begin
         pos = lane * INPUT_BITS + j;
         if (pos < VECTOR_BITS) begin
            v[j] = word[pos];
         end
      end
      return v;
   endfunction

   // Sign-extend or truncate a product to accumulator width
   function automatic acc_type extend_product(input prod_type p);
      acc_type r;
      for (int j = 0; j < ACC_BITS; j++) begin
         if (j < PROD_BITS) begin
            r[j] = p[j];
         end else begin
            r[j] = p[PROD_BITS-1];
         end
      end
      return r;
   endfunction

   // Sign-extend or truncate the partial sum to accumulator width
   function automatic acc_type extend_psum(input logic [PSUM_BITS-1:0] p);
      acc_type r;
      for (int j = 0; j < ACC_BITS; j++) begin
         if (j < PSUM_BITS) begin
            r[j] = p[j];
         end else begin
            r[j] = p[PSUM_BITS-1];
         end
      end
      return r;
   endfunction

   // Low result bits of an entry, zero-filled when the entry is narrower
   function automatic logic [RESULT_BITS-1:0] to_result(input acc_type v);
      logic [RESULT_BITS-1:0] r;
      for (int j = 0; j < RESULT_BITS; j++) begin
         if (j < ACC_BITS) begin
            r[j] = v[j];
         end else begin
            r[j] = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

### sv/dpa_front.sv
// ----------------------------------------------------------------------------
// dpa_front
// Input stage: takes a transaction, registers the lane products, then sums
// them with the optional partial sum and hands the job to the queue.
// ----------------------------------------------------------------------------
module dpa_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dpa_pkg::VECTOR_BITS-1:0]        req_vector_a,
   input  logic [dpa_pkg::VECTOR_BITS-1:0]        req_vector_b,
   input  logic signed [dpa_pkg::PSUM_BITS-1:0]   req_partial_sum,
   input  logic [dpa_pkg::ADDR_IN_BITS-1:0]       req_entry_address,
   input  logic                                   req_accumulate,
   input  logic                                   req_reduce_enable,
   input  logic                                   req_final_item,
   input  dpa_pkg::back_status_type               status,
   output logic                                   job_valid,
   input  logic                                   job_ready,
   output dpa_pkg::job_type                       job
);
   import dpa_pkg::*;

   logic      accept;
   logic      s1_valid_ff, s1_valid_in;
   prod_type  prod_ff [LANE_COUNT];
   prod_type  prod_in [LANE_COUNT];
   acc_type   psum_ff, psum_in;
   index_type index_ff, index_in;
   logic      accumulate_ff, accumulate_in;
   logic      final_ff, final_in;
   acc_type   total;
   lane_type  lane_a [LANE_COUNT];
   lane_type  lane_b [LANE_COUNT];

   // Hold off while the accumulator file is being cleared
   assign req_ready = !status.clearing && (!s1_valid_ff || job_ready);
   assign accept    = req_valid && req_ready;

   // Lane products and captured fields
   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         lane_a[i]  = lane_value(req_vector_a, i);
         lane_b[i]  = lane_value(req_vector_b, i);
         prod_in[i] = accept ? lane_a[i] * lane_b[i] : prod_ff[i];
      end
      psum_in       = accept ? (req_reduce_enable ? extend_psum(req_partial_sum) : '0)
                             : psum_ff;
      index_in      = accept ? ADDR_BITS'(req_entry_address) : index_ff;
      accumulate_in = accept ? req_accumulate : accumulate_ff;
      final_in      = accept ? req_final_item : final_ff;
      s1_valid_in   = accept ? 1'b1 : (job_ready ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      psum_ff       <= psum_in;
      index_ff      <= index_in;
      accumulate_ff <= accumulate_in;
      final_ff      <= final_in;
   end

   // Sum of products plus partial sum, wrapping at accumulator width
   always_comb begin
      total = psum_ff;
      for (int i = 0; i < LANE_COUNT; i++) begin
         total = total + extend_product(prod_ff[i]);
      end
   end

   assign job_valid      = s1_valid_ff;
   assign job.total      = total;
   assign job.index      = index_ff;
   assign job.accumulate = accumulate_ff;
   assign job.final_item = final_ff;

endmodule

### sv/dpa_queue.sv
// ----------------------------------------------------------------------------
// dpa_queue
// Small first-in first-out queue of jobs between front and back ends.
// ----------------------------------------------------------------------------
module dpa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dpa_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dpa_pkg::job_type pop_data
);
   import dpa_pkg::*;

   job_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/dpa_back.sv
// ----------------------------------------------------------------------------
// dpa_back
// Accumulator file and its update sequencer: clears the file after reset,
// then reads, updates and writes one entry per job, and holds the result
// transaction in an output register.
// ----------------------------------------------------------------------------
module dpa_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   output logic                                  job_ready,
   input  dpa_pkg::job_type                      job,
   output dpa_pkg::back_status_type              status,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dpa_pkg::RESULT_BITS-1:0] rsp_result_value
);
   import dpa_pkg::*;

   localparam index_type LAST_INDEX = ADDR_BITS'(ENTRY_COUNT - 1);

   back_state_type         state_ff, state_in;
   index_type              clear_ptr_ff, clear_ptr_in;
   job_type                job_ff, job_in;
   acc_type                rd_data_ff;
   acc_type                acc_mem_ff [ENTRY_COUNT];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] rsp_value_ff, rsp_value_in;

   logic      slot_free, pop, load_rsp, mem_we;
   index_type mem_wa;
   acc_type   mem_wd, new_value;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = job_valid && job_ready;
   assign new_value = job_ff.accumulate ? rd_data_ff + job_ff.total : job_ff.total;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_CLEAR: begin
            if (clear_ptr_ff == LAST_INDEX) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (pop) begin
               state_in = BACK_UPDATE;
            end
         end
         BACK_UPDATE: begin
            state_in = BACK_IDLE;
         end
         default: begin
            state_in = BACK_CLEAR;
         end
      endcase
   end

   // State outputs
   always_comb begin
      job_ready       = 1'b0;
      mem_we          = 1'b0;
      mem_wa          = job_ff.index;
      mem_wd          = new_value;
      load_rsp        = 1'b0;
      status.clearing = 1'b0;
      case (state_ff)
         BACK_CLEAR: begin
            mem_we          = 1'b1;
            mem_wa          = clear_ptr_ff;
            mem_wd          = '0;
            status.clearing = 1'b1;
         end
         BACK_IDLE: begin
            job_ready = slot_free;
         end
         BACK_UPDATE: begin
            mem_we   = 1'b1;
            load_rsp = job_ff.final_item;
         end
         default: begin
            status.clearing = 1'b1;
         end
      endcase
   end

   // Register next values
   always_comb begin
      clear_ptr_in = (state_ff == BACK_CLEAR) ? clear_ptr_ff + 1'b1 : clear_ptr_ff;
      job_in       = pop ? job : job_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_value_in = load_rsp ? to_result(new_value) : rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         clear_ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Accumulator file: one write port, registered read of the queue head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= acc_mem_ff[job.index];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

### sv/dot_product_accumulator.sv
// Path: an accepted request passes the product registers, a queue slot, the back-end job
//   register and the response register before rsp_valid rises, later when the queue is busy.
// The back end takes a new job only in its idle state, not while it writes one back.
// Reset: synchronous, active high; afterwards all ENTRY_COUNT (512) entries of the
//   accumulator file are cleared to zero, one after another, with req_ready held low.
// ----------------------------------------------------------------------------
// dot_product_accumulator
// Signed lane-wise dot product with optional partial sum, accumulated into
// an addressed entry of an accumulator file; the final transaction of a
// sequence returns the entry's new value.
// ----------------------------------------------------------------------------
module dot_product_accumulator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dpa_pkg::VECTOR_BITS-1:0]        req_vector_a,
   input  logic [dpa_pkg::VECTOR_BITS-1:0]        req_vector_b,
   input  logic signed [dpa_pkg::PSUM_BITS-1:0]   req_partial_sum,
   input  logic [dpa_pkg::ADDR_IN_BITS-1:0]       req_entry_address,
   input  logic                                   req_accumulate,
   input  logic                                   req_reduce_enable,
   input  logic                                   req_final_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dpa_pkg::RESULT_BITS-1:0] rsp_result_value
);
   import dpa_pkg::*;

   back_status_type status;
   job_type         front_job, queue_job;
   logic            front_valid, front_ready;
   logic            queue_valid, queue_ready;

   // Front end: products and sum
   dpa_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_vector_a      (req_vector_a),
      .req_vector_b      (req_vector_b),
      .req_partial_sum   (req_partial_sum),
      .req_entry_address (req_entry_address),
      .req_accumulate    (req_accumulate),
      .req_reduce_enable (req_reduce_enable),
      .req_final_item    (req_final_item),
      .status            (status),
      .job_valid         (front_valid),
      .job_ready         (front_ready),
      .job               (front_job)
   );

   // Decoupling queue
   dpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_job)
   );

   // Back end: accumulator file update and response
   dpa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (queue_valid),
      .job_ready        (queue_ready),
      .job              (queue_job),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value)
   );

endmodule

### sv/dpa_checker.sv
// ----------------------------------------------------------------------------
// dpa_checker
// Port-level checks for the dot-product accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module dpa_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [dpa_pkg::RESULT_BITS-1:0] rsp_result_value
);
   import dpa_pkg::*;

   // Reset empties the response register and blocks new requests
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("response or request ready active after reset");

   // No request transaction is taken while reset is held
   assert property (@(posedge clock) reset |-> !(req_valid && req_ready))
      else $error("request taken during reset");

   // The clearing pass keeps requests out right after reset is released
   assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("request taken during accumulator clearing");

   // A stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
      else $error("stalled response dropped or changed");

endmodule

bind dot_product_accumulator dpa_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value)
);

### dv/tb_dot_product_accumulator.sv
// ----------------------------------------------------------------------------
// tb_dot_product_accumulator
// Self-checking bench for the dot-product accumulator. Transactions are
// predicted at acceptance against a mirror of the accumulator file. Each
// response is checked in order against the queue of pending entry values.
// Directed extremes come first, then back-pressure and drain phases, then
// random accumulation sequences with random gaps, then a full-rate tail.
// ----------------------------------------------------------------------------
module tb_dot_product_accumulator;

   import dpa_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [VECTOR_BITS-1:0]        req_vector_a = '0;
   logic [VECTOR_BITS-1:0]        req_vector_b = '0;
   logic signed [PSUM_BITS-1:0]   req_partial_sum = '0;
   logic [ADDR_IN_BITS-1:0]       req_entry_address = '0;
   logic                          req_accumulate = 1'b0;
   logic                          req_reduce_enable = 1'b0;
   logic                          req_final_item = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [RESULT_BITS-1:0] rsp_result_value;

   // Mirror of the accumulator file and the entry values still to come back
   acc_type                entry_mirror [ENTRY_COUNT];
   logic [RESULT_BITS-1:0] pending_values [$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  sender_gaps_on = 1'b1;
   bit  receiver_gaps_on = 1'b1;
   int  hold_request = 0;

   dot_product_accumulator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_vector_a      (req_vector_a),
      .req_vector_b      (req_vector_b),
      .req_partial_sum   (req_partial_sum),
      .req_entry_address (req_entry_address),
      .req_accumulate    (req_accumulate),
      .req_reduce_enable (req_reduce_enable),
      .req_final_item    (req_final_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Clear the mirror, as the block does after reset
   initial begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         entry_mirror[i] = '0;
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, pending_values.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Lane-wise signed dot product plus optional partial sum, wrapped
   function automatic acc_type lane_dot_total(input logic [VECTOR_BITS-1:0] a,
                                              input logic [VECTOR_BITS-1:0] b,
                                              input logic [PSUM_BITS-1:0]   psum,
                                              input logic                   add_psum);
      acc_type total;
      acc_type product;
      lane_type la;
      lane_type lb;
      total = '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
         la = a[i*INPUT_BITS +: INPUT_BITS];
         lb = b[i*INPUT_BITS +: INPUT_BITS];
         product = acc_type'(32'(signed'(la)) * 32'(signed'(lb)));
         total = total + product;
      end
      if (add_psum) begin
         total = total + acc_type'(signed'(psum));
      end
      return total;
   endfunction

   // Random packed lanes, biased towards the lane extremes, zero and minus one
   function automatic logic [VECTOR_BITS-1:0] random_lanes();
      logic [VECTOR_BITS-1:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            case ($urandom_range(0, 4))
               0: w[i*INPUT_BITS +: INPUT_BITS] = 8'h80;
               1: w[i*INPUT_BITS +: INPUT_BITS] = 8'h7F;
               2: w[i*INPUT_BITS +: INPUT_BITS] = 8'h00;
               3: w[i*INPUT_BITS +: INPUT_BITS] = 8'hFF;
               default: ;
            endcase
         end
      end
      return w;
   endfunction

   // Sender: entered and left just after a falling edge
   task automatic send_item(input logic [VECTOR_BITS-1:0]  a,
                            input logic [VECTOR_BITS-1:0]  b,
                            input logic [PSUM_BITS-1:0]    psum,
                            input logic [ADDR_IN_BITS-1:0] addr,
                            input logic                    acc,
                            input logic                    red,
                            input logic                    fin);
      int      gap;
      acc_type total;
      int      idx;
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         repeat (gap) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_vector_a      <= a;
      req_vector_b      <= b;
      req_partial_sum   <= psum;
      req_entry_address <= addr;
      req_accumulate    <= acc;
      req_reduce_enable <= red;
      req_final_item    <= fin;
      req_valid         <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      // Transaction accepted: update the mirror and queue the response
      total = lane_dot_total(a, b, psum, red);
      idx = int'(addr) % ENTRY_COUNT;
      if (acc) begin
         entry_mirror[idx] = entry_mirror[idx] + total;
      end else begin
         entry_mirror[idx] = total;
      end
      if (fin) begin
         pending_values.push_back(entry_mirror[idx][RESULT_BITS-1:0]);
      end
      @(negedge clock);
   endtask

   // Receiver: random stall bursts and requested long holds
   initial begin
      int idle_left;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            idle_left = hold_request;
            hold_request = 0;
         end
         if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else if (receiver_gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            idle_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Response check against the oldest pending value
   always @(posedge clock) begin
      logic [RESULT_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time,
                     rsp_result_value);
            mismatch_count++;
         end else begin
            want = pending_values.pop_front();
            if (rsp_result_value !== want) begin
               $display("%0t: result_value mismatch, expected %h, actual %h", $time,
                        want, rsp_result_value);
               mismatch_count++;
            end
         end
      end
   end

   // Lane and partial-sum extremes, wrapping, reset contents, forwarding
   task automatic test_directed_extremes();
      send_item({8{8'h80}}, {8{8'h80}}, 32'h0, 9'd0, 1'b0, 1'b0, 1'b1);
      send_item({8{8'h80}}, {8{8'h7F}}, 32'h0, 9'd0, 1'b1, 1'b0, 1'b1);
      send_item({8{8'h7F}}, {8{8'h7F}}, 32'h0, 9'd511, 1'b0, 1'b0, 1'b1);
      send_item({8{8'hFF}}, {8{8'hFF}}, 32'h7FFF_FFFF, 9'd511, 1'b1, 1'b1, 1'b1);
      send_item('0, '0, 32'h8000_0000, 9'd1, 1'b0, 1'b1, 1'b1);
      // partial sum ignored when not reducing
      send_item('0, '0, 32'h8000_0000, 9'd1, 1'b0, 1'b0, 1'b1);
      // accumulation wraps past the positive limit
      send_item('0, '0, 32'h7FFF_FFFF, 9'd2, 1'b0, 1'b1, 1'b0);
      send_item('0, '0, 32'h7FFF_FFFF, 9'd2, 1'b1, 1'b1, 1'b1);
      send_item({8{8'h80}}, {8{8'h80}}, 32'h8000_0000, 9'd2, 1'b1, 1'b1, 1'b1);
      // mixed lanes, alternating bit patterns
      send_item(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'h1234_5678,
                9'd3, 1'b0, 1'b1, 1'b0);
      send_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF,
                9'd3, 1'b1, 1'b1, 1'b1);
      // entry never written reads as cleared
      send_item(64'h0000_0000_0000_0102, 64'h0000_0000_0000_0304, 32'h0, 9'd100,
                1'b1, 1'b0, 1'b1);
      // back-to-back transactions to one entry
      send_item({8{8'h7F}}, {8{8'h80}}, 32'h0, 9'd4, 1'b0, 1'b0, 1'b1);
      send_item({8{8'h7F}}, {8{8'h80}}, 32'h0, 9'd4, 1'b1, 1'b0, 1'b1);
      send_item({8{8'h7F}}, {8{8'h80}}, 32'h0, 9'd4, 1'b1, 1'b0, 1'b0);
      send_item({8{8'h7F}}, {8{8'h80}}, 32'h0, 9'd4, 1'b1, 1'b0, 1'b1);
      // overwrite after accumulating
      send_item(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001, 32'h0, 9'd4,
                1'b0, 1'b0, 1'b1);
      // top address bit, single top lane
      send_item(64'h8000_0000_0000_0000, 64'h7F00_0000_0000_0000, 32'h0000_0001,
                9'd256, 1'b0, 1'b1, 1'b1);
      send_item({8{8'hFF}}, {8{8'h01}}, 32'h8000_0000, 9'd256, 1'b1, 1'b1, 1'b1);
      send_item('1, '1, '1, 9'd511, 1'b1, 1'b1, 1'b1);
   endtask

   // Long receiver hold while the sender keeps offering
   task automatic test_output_backpressure();
      hold_request = 80;
      for (int i = 0; i < 30; i++) begin
         send_item(random_lanes(), random_lanes(), $urandom, 9'($urandom_range(0, 7)),
                   1'($urandom), 1'($urandom), 1'b1);
      end
   endtask

   // Sender waits for every pending response before going on
   task automatic test_drain_pause();
      for (int i = 0; i < 10; i++) begin
         send_item(random_lanes(), random_lanes(), $urandom, 9'($urandom_range(0, 511)),
                   1'($urandom), 1'($urandom), 1'($urandom));
      end
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_values.size() != 0) begin
         @(negedge clock);
      end
      for (int i = 0; i < 10; i++) begin
         send_item(random_lanes(), random_lanes(), $urandom, 9'($urandom_range(0, 511)),
                   1'b1, 1'($urandom), 1'b1);
      end
   endtask

   // Overwrite, accumulate a few, then final; some noise mixed in
   task automatic test_random_sequences(input int item_total);
      int sent;
      int len;
      logic [ADDR_IN_BITS-1:0] addr;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 4) == 0) begin
            send_item(random_lanes(), random_lanes(), $urandom, 9'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end else begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 0) begin
               addr = 9'($urandom_range(0, 3));
            end else begin
               addr = 9'($urandom_range(0, 511));
            end
            for (int i = 0; i < len; i++) begin
               send_item(random_lanes(), random_lanes(), $urandom, addr,
                         (i != 0), 1'($urandom), (i == len - 1));
            end
            sent += len;
         end
      end
   endtask

   // Full rate on both sides
   task automatic test_full_rate();
      sender_gaps_on = 1'b0;
      receiver_gaps_on = 1'b0;
      test_random_sequences(150);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_output_backpressure();
      test_drain_pause();
      test_random_sequences(880);
      test_full_rate();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_values.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
